### rtl/multiqueue_dary_heap_engine_defines.svh
// ----------------------------------------------------------------------------
// Multiqueue heap engine assertion macros
// Shared clocked assertion forms, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef MULTIQUEUE_DARY_HEAP_ENGINE_DEFINES_SVH
`define MULTIQUEUE_DARY_HEAP_ENGINE_DEFINES_SVH
`ifndef SYNTH
`define MDH_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MDH_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define MDH_ASSERT(lbl, clk, rst_n, prop, msg)
`define MDH_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

### rtl/mdh_pkg.sv
// ----------------------------------------------------------------------------
// mdh_pkg
// Constants, codes and types of the multiqueue heap engine.
// ----------------------------------------------------------------------------
`default_nettype none
package mdh_pkg;
  localparam int NUM_HEAPS    = 8;
  localparam int HEAP_DEPTH   = 256;
  localparam int HEAP_ARITY   = 8;
  localparam int HANDLE_WIDTH = 16;
  localparam int PRIO_W       = 16;
  localparam int HEAPW        = $clog2(NUM_HEAPS);
  localparam int IDXW         = $clog2(HEAP_DEPTH);
  localparam int CNTW         = $clog2(HEAP_DEPTH + 1);
  localparam int ADDRW        = HEAPW + IDXW;
  localparam int CIDXW        = IDXW + $clog2(HEAP_ARITY) + 1;
  localparam int CCNTW        = $clog2(HEAP_ARITY + 1);
  localparam int SLOT_W       = HANDLE_WIDTH + PRIO_W;
  localparam int MEM_DEPTH    = NUM_HEAPS * HEAP_DEPTH;

  localparam logic [PRIO_W-1:0] EMPTY_PRIO = 16'h7fff;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [HANDLE_WIDTH-1:0] handle;
    logic [PRIO_W-1:0]       prio;
  } slot_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_LIFT_CHK, ST_LIFT_CMP, ST_DEL_ROOT,
    ST_DEL_LAST, ST_SD_INIT, ST_SD_CHK, ST_SD_CMP
  } state_t;

  typedef enum logic [1:0] {RD_ROOT, RD_LAST, RD_PARENT, RD_CHILD} rd_sel_t;
  typedef enum logic [1:0] {WR_CUR, WR_RDATA, WR_BEST} wr_sel_t;
  typedef enum logic [2:0] {
    RES_NONE, RES_INS, RES_FULL, RES_EMPTY, RES_QUERY, RES_DEL, RES_BAD
  } res_t;

  typedef struct packed {
    logic    latch_in;
    logic    latch_pick;
    logic    mem_rd;
    rd_sel_t rd_sel;
    logic    mem_wr;
    wr_sel_t wr_sel;
    logic    ins_init;
    logic    lift_step;
    logic    got_cap;
    logic    cur_load;
    logic    cache_empty;
    logic    child_init;
    logic    child_cmp;
    logic    descend;
    logic    cache_root;
    res_t    res;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd_code;
    logic       full;
    logic       del_empty;
    logic       idx_zero;
    logic       cur_gt_rd;
    logic       last_one;
    logic       child_more;
    logic       best_none;
  } dp_stat_t;
endpackage
`default_nettype wire

### rtl/mdh_ram.sv
// ----------------------------------------------------------------------------
// mdh_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module mdh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

### rtl/mdh_dp.sv
// ----------------------------------------------------------------------------
// mdh_dp
// Datapath: heap memory, counts, cached minima, sift registers and result.
// ----------------------------------------------------------------------------
`default_nettype none
module mdh_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire mdh_pkg::dp_cmd_t                  cmd,
  output mdh_pkg::dp_stat_t                      stat,
  input  wire logic [1:0]                        in_command,
  input  wire logic [mdh_pkg::HEAPW-1:0]         in_heap_a,
  input  wire logic [mdh_pkg::HEAPW-1:0]         in_heap_b,
  input  wire logic signed [mdh_pkg::PRIO_W-1:0] in_priority_req,
  input  wire logic [mdh_pkg::HANDLE_WIDTH-1:0]  in_task_handle,
  output logic                                   out_valid,
  output logic [1:0]                             out_status,
  output logic [mdh_pkg::HANDLE_WIDTH-1:0]       out_task_out,
  output logic signed [mdh_pkg::PRIO_W-1:0]      out_priority_out
);
  logic [1:0]                       cmd_r;
  logic [mdh_pkg::HEAPW-1:0]        ha_r, hb_r, pick_r, sel, rheap;
  mdh_pkg::slot_t                   in_r, cur_r, got_r, best_r, rd, wdata;
  logic [mdh_pkg::IDXW-1:0]         idx_r, bidx_r, parent_idx, ridx;
  logic [mdh_pkg::CIDXW-1:0]        cidx_r;
  logic [mdh_pkg::CCNTW-1:0]        ccnt_r;
  logic                             bnone_r;
  logic [mdh_pkg::CNTW-1:0]         count_r [mdh_pkg::NUM_HEAPS];
  logic [mdh_pkg::PRIO_W-1:0]       cache_r [mdh_pkg::NUM_HEAPS];
  logic [mdh_pkg::PRIO_W-1:0]       pa, pb, minp;
  logic [mdh_pkg::SLOT_W-1:0]       rdata;
  logic                             out_valid_r;
  logic [1:0]                       out_status_r;
  logic [mdh_pkg::HANDLE_WIDTH-1:0] out_task_r;
  logic [mdh_pkg::PRIO_W-1:0]       out_prio_r;

  assign rd         = mdh_pkg::slot_t'(rdata);
  assign pa         = cache_r[ha_r];
  assign pb         = cache_r[hb_r];
  assign minp       = ($signed(pa) > $signed(pb)) ? pb : pa;
  assign sel        = (cmd_r == mdh_pkg::CMD_INSERT) ? ha_r :
                      (($signed(pa) > $signed(pb)) ? hb_r : ha_r);
  assign rheap      = cmd.latch_pick ? sel : pick_r;
  assign parent_idx = (idx_r - mdh_pkg::IDXW'(1)) / mdh_pkg::IDXW'(mdh_pkg::HEAP_ARITY);

  always_comb begin
    case (cmd.rd_sel)
      mdh_pkg::RD_ROOT:   ridx = '0;
      mdh_pkg::RD_LAST:   ridx = mdh_pkg::IDXW'(count_r[pick_r] - mdh_pkg::CNTW'(1));
      mdh_pkg::RD_PARENT: ridx = parent_idx;
      default:            ridx = cidx_r[mdh_pkg::IDXW-1:0];
    endcase
    case (cmd.wr_sel)
      mdh_pkg::WR_CUR:   wdata = cur_r;
      mdh_pkg::WR_RDATA: wdata = rd;
      default:           wdata = best_r;
    endcase
  end

  always_comb begin
    stat.cmd_code   = cmd_r;
    stat.full       = count_r[ha_r] >= mdh_pkg::CNTW'(mdh_pkg::HEAP_DEPTH);
    stat.del_empty  = (minp == mdh_pkg::EMPTY_PRIO) || (count_r[sel] == '0);
    stat.idx_zero   = idx_r == '0;
    stat.cur_gt_rd  = $signed(cur_r.prio) > $signed(rd.prio);
    stat.last_one   = count_r[pick_r] == mdh_pkg::CNTW'(1);
    stat.child_more = (ccnt_r < mdh_pkg::CCNTW'(mdh_pkg::HEAP_ARITY)) &&
                      (cidx_r < mdh_pkg::CIDXW'(count_r[pick_r]));
    stat.best_none  = bnone_r;
  end

  mdh_ram #(
    .WIDTH(mdh_pkg::SLOT_W),
    .DEPTH(mdh_pkg::MEM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.mem_wr),
    .waddr({pick_r, idx_r}),
    .wdata(wdata),
    .re   (cmd.mem_rd),
    .raddr({rheap, ridx}),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_r <= in_command;
      ha_r  <= in_heap_a;
      hb_r  <= in_heap_b;
      in_r  <= {in_task_handle, in_priority_req};
    end
    if (cmd.latch_pick) begin
      pick_r <= sel;
    end
    if (cmd.ins_init) begin
      idx_r <= count_r[ha_r][mdh_pkg::IDXW-1:0];
      cur_r <= in_r;
    end
    if (cmd.lift_step) begin
      idx_r <= parent_idx;
    end
    if (cmd.got_cap) begin
      got_r <= rd;
    end
    if (cmd.cur_load) begin
      cur_r <= rd;
      idx_r <= '0;
    end
    if (cmd.child_init) begin
      cidx_r  <= mdh_pkg::CIDXW'(idx_r) * mdh_pkg::CIDXW'(mdh_pkg::HEAP_ARITY) +
                 mdh_pkg::CIDXW'(1);
      ccnt_r  <= '0;
      best_r  <= cur_r;
      bnone_r <= 1'b1;
    end
    if (cmd.child_cmp) begin
      if ($signed(rd.prio) < $signed(best_r.prio)) begin
        best_r  <= rd;
        bidx_r  <= cidx_r[mdh_pkg::IDXW-1:0];
        bnone_r <= 1'b0;
      end
      cidx_r <= cidx_r + mdh_pkg::CIDXW'(1);
      ccnt_r <= ccnt_r + mdh_pkg::CCNTW'(1);
    end
    if (cmd.descend) begin
      idx_r <= bidx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mdh_pkg::NUM_HEAPS; i++) begin
        count_r[i] <= '0;
        cache_r[i] <= mdh_pkg::EMPTY_PRIO;
      end
    end else begin
      if (cmd.ins_init) begin
        count_r[ha_r] <= count_r[ha_r] + mdh_pkg::CNTW'(1);
        if ($signed(in_r.prio) < $signed(cache_r[ha_r])) begin
          cache_r[ha_r] <= in_r.prio;
        end
      end
      if (cmd.cur_load) begin
        count_r[pick_r] <= count_r[pick_r] - mdh_pkg::CNTW'(1);
      end
      if (cmd.cache_empty) begin
        cache_r[pick_r] <= mdh_pkg::EMPTY_PRIO;
      end
      if (cmd.cache_root && cmd.mem_wr && idx_r == '0) begin
        cache_r[pick_r] <= wdata.prio;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.res != mdh_pkg::RES_NONE;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.res)
      mdh_pkg::RES_INS: begin
        out_status_r <= mdh_pkg::STATUS_OK;
        out_task_r   <= '0;
        out_prio_r   <= '0;
      end
      mdh_pkg::RES_FULL: begin
        out_status_r <= mdh_pkg::STATUS_FULL;
        out_task_r   <= '0;
        out_prio_r   <= '0;
      end
      mdh_pkg::RES_EMPTY: begin
        out_status_r <= mdh_pkg::STATUS_EMPTY;
        out_task_r   <= '0;
        out_prio_r   <= mdh_pkg::EMPTY_PRIO;
      end
      mdh_pkg::RES_QUERY: begin
        out_status_r <= mdh_pkg::STATUS_OK;
        out_task_r   <= '0;
        out_prio_r   <= minp;
      end
      mdh_pkg::RES_DEL: begin
        out_status_r <= mdh_pkg::STATUS_OK;
        out_task_r   <= got_r.handle;
        out_prio_r   <= got_r.prio;
      end
      mdh_pkg::RES_BAD: begin
        out_status_r <= mdh_pkg::STATUS_OK;
        out_task_r   <= '0;
        out_prio_r   <= mdh_pkg::EMPTY_PRIO;
      end
      default: begin
        out_status_r <= out_status_r;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_task_out     = out_task_r;
  assign out_priority_out = out_prio_r;
endmodule
`default_nettype wire

### rtl/mdh_ctrl.sv
// ----------------------------------------------------------------------------
// mdh_ctrl
// Controller: sequences insert sift-up, delete sift-down and queries.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multiqueue_dary_heap_engine_defines.svh"
module mdh_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire mdh_pkg::dp_stat_t stat,
  output mdh_pkg::dp_cmd_t       cmd
);
  mdh_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mdh_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = state_r != mdh_pkg::ST_IDLE;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mdh_pkg::ST_IDLE: begin
        if (start) state_nxt = mdh_pkg::ST_DECODE;
      end
      mdh_pkg::ST_DECODE: begin
        unique case (stat.cmd_code)
          mdh_pkg::CMD_INSERT: state_nxt = stat.full ? mdh_pkg::ST_IDLE : mdh_pkg::ST_LIFT_CHK;
          mdh_pkg::CMD_DELETE: state_nxt = stat.del_empty ? mdh_pkg::ST_IDLE :
                                                            mdh_pkg::ST_DEL_ROOT;
          default:             state_nxt = mdh_pkg::ST_IDLE;
        endcase
      end
      mdh_pkg::ST_LIFT_CHK: begin
        state_nxt = stat.idx_zero ? mdh_pkg::ST_IDLE : mdh_pkg::ST_LIFT_CMP;
      end
      mdh_pkg::ST_LIFT_CMP: begin
        state_nxt = stat.cur_gt_rd ? mdh_pkg::ST_IDLE : mdh_pkg::ST_LIFT_CHK;
      end
      mdh_pkg::ST_DEL_ROOT: state_nxt = mdh_pkg::ST_DEL_LAST;
      mdh_pkg::ST_DEL_LAST: begin
        state_nxt = stat.last_one ? mdh_pkg::ST_IDLE : mdh_pkg::ST_SD_INIT;
      end
      mdh_pkg::ST_SD_INIT: state_nxt = mdh_pkg::ST_SD_CHK;
      mdh_pkg::ST_SD_CHK: begin
        if (stat.child_more) state_nxt = mdh_pkg::ST_SD_CMP;
        else if (stat.best_none) state_nxt = mdh_pkg::ST_IDLE;
        else state_nxt = mdh_pkg::ST_SD_INIT;
      end
      mdh_pkg::ST_SD_CMP: state_nxt = mdh_pkg::ST_SD_CHK;
      default: state_nxt = mdh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = mdh_pkg::RD_ROOT;
    cmd.wr_sel = mdh_pkg::WR_CUR;
    cmd.res    = mdh_pkg::RES_NONE;
    unique case (state_r)
      mdh_pkg::ST_IDLE: begin
        cmd.latch_in = start;
      end
      mdh_pkg::ST_DECODE: begin
        cmd.latch_pick = 1'b1;
        unique case (stat.cmd_code)
          mdh_pkg::CMD_INSERT: begin
            if (stat.full) cmd.res = mdh_pkg::RES_FULL;
            else cmd.ins_init = 1'b1;
          end
          mdh_pkg::CMD_DELETE: begin
            if (stat.del_empty) begin
              cmd.res = mdh_pkg::RES_EMPTY;
            end else begin
              cmd.mem_rd = 1'b1;
              cmd.rd_sel = mdh_pkg::RD_ROOT;
            end
          end
          mdh_pkg::CMD_QUERY: cmd.res = mdh_pkg::RES_QUERY;
          default:            cmd.res = mdh_pkg::RES_BAD;
        endcase
      end
      mdh_pkg::ST_LIFT_CHK: begin
        if (stat.idx_zero) begin
          cmd.mem_wr = 1'b1;
          cmd.res    = mdh_pkg::RES_INS;
        end else begin
          cmd.mem_rd = 1'b1;
          cmd.rd_sel = mdh_pkg::RD_PARENT;
        end
      end
      mdh_pkg::ST_LIFT_CMP: begin
        cmd.mem_wr = 1'b1;
        if (stat.cur_gt_rd) begin
          cmd.res = mdh_pkg::RES_INS;
        end else begin
          cmd.wr_sel    = mdh_pkg::WR_RDATA;
          cmd.lift_step = 1'b1;
        end
      end
      mdh_pkg::ST_DEL_ROOT: begin
        cmd.got_cap = 1'b1;
        cmd.mem_rd  = 1'b1;
        cmd.rd_sel  = mdh_pkg::RD_LAST;
      end
      mdh_pkg::ST_DEL_LAST: begin
        cmd.cur_load = 1'b1;
        if (stat.last_one) begin
          cmd.cache_empty = 1'b1;
          cmd.res         = mdh_pkg::RES_DEL;
        end
      end
      mdh_pkg::ST_SD_INIT: begin
        cmd.child_init = 1'b1;
      end
      mdh_pkg::ST_SD_CHK: begin
        if (stat.child_more) begin
          cmd.mem_rd = 1'b1;
          cmd.rd_sel = mdh_pkg::RD_CHILD;
        end else if (stat.best_none) begin
          cmd.mem_wr     = 1'b1;
          cmd.cache_root = 1'b1;
          cmd.res        = mdh_pkg::RES_DEL;
        end else begin
          cmd.mem_wr     = 1'b1;
          cmd.wr_sel     = mdh_pkg::WR_BEST;
          cmd.cache_root = 1'b1;
          cmd.descend    = 1'b1;
        end
      end
      mdh_pkg::ST_SD_CMP: begin
        cmd.child_cmp = 1'b1;
      end
      default: begin
        cmd.res = mdh_pkg::RES_NONE;
      end
    endcase
  end

  `MDH_ASSERT(a_accept_decode, clk, rst_n, (state_r == mdh_pkg::ST_IDLE && start) |=> (state_r == mdh_pkg::ST_DECODE), "accepted item did not reach decode")
  `MDH_ASSERT_NEVER(a_rd_wr_excl, clk, rst_n, cmd.mem_rd && cmd.mem_wr, "heap read and write in one cycle")
  `MDH_ASSERT(a_res_ends, clk, rst_n, (cmd.res != mdh_pkg::RES_NONE) |-> (state_nxt == mdh_pkg::ST_IDLE), "result issued while work continues")
endmodule
`default_nettype wire

### rtl/multiqueue_dary_heap_engine.sv
// ----------------------------------------------------------------------------
// multiqueue_dary_heap_engine
// Relaxed priority queue of eight 8-ary min-heaps with cached minima.
//
//   channel  handshake            fields
//   in       start & !busy        in_command in_heap_a in_heap_b
//                                 in_priority_req in_task_handle
//   out      out_valid (1 cycle)  out_status out_task_out out_priority_out
//
// One item at a time. Query, full and empty finish in decode. Insert climbs
// one level per parent read and write; delete reads the root and the last
// slot, then per level reads each child in turn; each step is bounded by the
// single-port read of the heap RAM.
// Reset clears counts and cached minima at once; the heap RAM needs no pass.
// Result appears the cycle after the work ends; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none
module multiqueue_dary_heap_engine (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        in_command,
  input  wire logic [mdh_pkg::HEAPW-1:0]         in_heap_a,
  input  wire logic [mdh_pkg::HEAPW-1:0]         in_heap_b,
  input  wire logic signed [mdh_pkg::PRIO_W-1:0] in_priority_req,
  input  wire logic [mdh_pkg::HANDLE_WIDTH-1:0]  in_task_handle,
  output logic                                   out_valid,
  output logic [1:0]                             out_status,
  output logic [mdh_pkg::HANDLE_WIDTH-1:0]       out_task_out,
  output logic signed [mdh_pkg::PRIO_W-1:0]      out_priority_out
);
  mdh_pkg::dp_cmd_t  cmd;
  mdh_pkg::dp_stat_t stat;

  mdh_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .stat (stat),
    .cmd  (cmd)
  );

  mdh_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_command      (in_command),
    .in_heap_a       (in_heap_a),
    .in_heap_b       (in_heap_b),
    .in_priority_req (in_priority_req),
    .in_task_handle  (in_task_handle),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_task_out    (out_task_out),
    .out_priority_out(out_priority_out)
  );
endmodule
`default_nettype wire

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives insert, delete-min, query and unused-code items into the multiqueue
// heap engine, predicts every result with a behavioral copy of the eight heaps,
// and compares each strobed result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int MAX_CYCLES = 400000;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] task_id;
    logic [15:0] prio;
  } result_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [2:0]  ha;
    logic [2:0]  hb;
    logic [15:0] prio;
    logic [15:0] handle;
    logic        fixed;
    result_t     res;
  } stim_t;

  logic clk, rst_n, start;
  logic busy, out_valid;
  logic [1:0] in_command, out_status;
  logic [2:0] in_heap_a, in_heap_b;
  logic signed [15:0] in_priority_req, out_priority_out;
  logic [15:0] in_task_handle, out_task_out;

  multiqueue_dary_heap_engine dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_heap_a(in_heap_a), .in_heap_b(in_heap_b),
    .in_priority_req(in_priority_req), .in_task_handle(in_task_handle),
    .out_valid(out_valid), .out_status(out_status), .out_task_out(out_task_out),
    .out_priority_out(out_priority_out)
  );

  logic [15:0] heap_handle [mdh_pkg::NUM_HEAPS][mdh_pkg::HEAP_DEPTH];
  logic signed [15:0] heap_prio [mdh_pkg::NUM_HEAPS][mdh_pkg::HEAP_DEPTH];
  int unsigned heap_fill [mdh_pkg::NUM_HEAPS];
  logic signed [15:0] heap_min [mdh_pkg::NUM_HEAPS];

  result_t pending_results[$];
  stim_t dir_rows[$];
  int errors = 0;
  int cycles = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("multiqueue_dary_heap_engine test failed");
      $finish;
    end
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic void swap_slot(int h, int i, int j);
    logic [15:0] th;
    logic signed [15:0] tp;
    th = heap_handle[h][i]; tp = heap_prio[h][i];
    heap_handle[h][i] = heap_handle[h][j]; heap_prio[h][i] = heap_prio[h][j];
    heap_handle[h][j] = th; heap_prio[h][j] = tp;
  endfunction

  function automatic result_t predict_heap_op(logic [1:0] cmd, logic [2:0] ha,
                                              logic [2:0] hb, logic signed [15:0] pr,
                                              logic [15:0] hd);
    result_t r;
    int n, idx, par, best, first, pick;
    logic signed [15:0] p;
    r = '{status: mdh_pkg::STATUS_OK, task_id: 16'd0, prio: mdh_pkg::EMPTY_PRIO};
    case (cmd)
      mdh_pkg::CMD_INSERT: begin
        n = heap_fill[ha];
        r.prio = 16'd0;
        if (n >= mdh_pkg::HEAP_DEPTH) begin
          r.status = mdh_pkg::STATUS_FULL;
        end else begin
          heap_handle[ha][n] = hd; heap_prio[ha][n] = pr;
          heap_fill[ha] = n + 1;
          idx = n;
          while (idx > 0) begin
            par = (idx - 1) / mdh_pkg::HEAP_ARITY;
            if (heap_prio[ha][idx] > heap_prio[ha][par]) break;
            swap_slot(ha, idx, par);
            idx = par;
          end
          if (pr < heap_min[ha]) heap_min[ha] = pr;
        end
      end
      mdh_pkg::CMD_DELETE: begin
        pick = ha; p = heap_min[ha];
        if (p > heap_min[hb]) begin
          pick = hb; p = heap_min[hb];
        end
        if (p == $signed(mdh_pkg::EMPTY_PRIO) || heap_fill[pick] == 0) begin
          r.status = mdh_pkg::STATUS_EMPTY;
        end else begin
          r.task_id = heap_handle[pick][0];
          r.prio = heap_prio[pick][0];
          n = heap_fill[pick] - 1;
          heap_handle[pick][0] = heap_handle[pick][n];
          heap_prio[pick][0] = heap_prio[pick][n];
          heap_fill[pick] = n;
          if (n > 0) begin
            idx = 0;
            forever begin
              first = idx * mdh_pkg::HEAP_ARITY + 1;
              best = idx;
              for (int c = first; c < n && c < first + mdh_pkg::HEAP_ARITY; c++)
                if (heap_prio[pick][c] < heap_prio[pick][best]) best = c;
              if (best == idx) break;
              swap_slot(pick, idx, best);
              idx = best;
            end
            heap_min[pick] = heap_prio[pick][0];
          end else begin
            heap_min[pick] = mdh_pkg::EMPTY_PRIO;
          end
        end
      end
      mdh_pkg::CMD_QUERY: begin
        p = heap_min[ha];
        if (heap_min[hb] < p) p = heap_min[hb];
        r.prio = p;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", out_status, -1);
      end else begin
        e = pending_results.pop_front();
        if (out_status !== e.status) report("status", out_status, e.status);
        if (out_task_out !== e.task_id) report("task_out", out_task_out, e.task_id);
        if (out_priority_out !== $signed(e.prio))
          report("priority_out", out_priority_out, $signed(e.prio));
      end
    end
  end

  task automatic send_item(stim_t s);
    result_t r;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b1;
    in_command <= s.cmd; in_heap_a <= s.ha; in_heap_b <= s.hb;
    in_priority_req <= s.prio; in_task_handle <= s.handle;
    r = predict_heap_op(s.cmd, s.ha, s.hb, s.prio, s.handle);
    if (s.fixed && r !== s.res) report("directed row", int'(r), int'(s.res));
    pending_results.push_back(r);
    @(posedge clk);
    start <= 1'b0;
  endtask

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    repeat (g) @(posedge clk);
  endtask

  function automatic stim_t row(logic [1:0] c, logic [2:0] a, logic [2:0] b,
                                logic [15:0] p, logic [15:0] h, logic f,
                                logic [1:0] st, logic [15:0] t, logic [15:0] rp);
    stim_t s;
    s.cmd = c; s.ha = a; s.hb = b; s.prio = p; s.handle = h; s.fixed = f;
    s.res = '{status: st, task_id: t, prio: rp};
    return s;
  endfunction

  initial begin
    stim_t s;
    int target, wait_cycles;
    rst_n = 1'b0; start = 1'b0;
    in_command = '0; in_heap_a = '0; in_heap_b = '0;
    in_priority_req = '0; in_task_handle = '0;
    for (int h = 0; h < mdh_pkg::NUM_HEAPS; h++) begin
      heap_fill[h] = 0; heap_min[h] = mdh_pkg::EMPTY_PRIO;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    dir_rows.push_back(row(mdh_pkg::CMD_QUERY, 0, 7, 0, 0, 1,
                           mdh_pkg::STATUS_OK, 0, mdh_pkg::EMPTY_PRIO));
    dir_rows.push_back(row(mdh_pkg::CMD_DELETE, 0, 7, 0, 0, 1,
                           mdh_pkg::STATUS_EMPTY, 0, mdh_pkg::EMPTY_PRIO));
    dir_rows.push_back(row(CMD_UNUSED, 7, 0, 16'hffff, 16'hffff, 1,
                           mdh_pkg::STATUS_OK, 0, mdh_pkg::EMPTY_PRIO));
    dir_rows.push_back(row(mdh_pkg::CMD_INSERT, 1, 0, 16'h7fff, 16'h1234, 1,
                           mdh_pkg::STATUS_OK, 0, 0));
    dir_rows.push_back(row(mdh_pkg::CMD_QUERY, 1, 1, 0, 0, 1,
                           mdh_pkg::STATUS_OK, 0, mdh_pkg::EMPTY_PRIO));
    dir_rows.push_back(row(mdh_pkg::CMD_DELETE, 1, 1, 0, 0, 1,
                           mdh_pkg::STATUS_EMPTY, 0, mdh_pkg::EMPTY_PRIO));
    dir_rows.push_back(row(mdh_pkg::CMD_INSERT, 2, 0, 16'h8000, 16'hffff, 1,
                           mdh_pkg::STATUS_OK, 0, 0));
    dir_rows.push_back(row(mdh_pkg::CMD_INSERT, 2, 0, 16'h8000, 16'h0000, 1,
                           mdh_pkg::STATUS_OK, 0, 0));
    dir_rows.push_back(row(mdh_pkg::CMD_INSERT, 2, 0, 16'h7ffe, 16'haaaa, 1,
                           mdh_pkg::STATUS_OK, 0, 0));
    dir_rows.push_back(row(mdh_pkg::CMD_QUERY, 7, 2, 0, 0, 1,
                           mdh_pkg::STATUS_OK, 0, 16'h8000));
    dir_rows.push_back(row(mdh_pkg::CMD_DELETE, 3, 2, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(mdh_pkg::CMD_DELETE, 2, 3, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(mdh_pkg::CMD_INSERT, 3, 0, 16'h0005, 16'h5555, 0, 0, 0, 0));
    dir_rows.push_back(row(mdh_pkg::CMD_INSERT, 4, 0, 16'h0005, 16'h6666, 0, 0, 0, 0));
    dir_rows.push_back(row(mdh_pkg::CMD_DELETE, 3, 4, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(mdh_pkg::CMD_DELETE, 2, 4, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(mdh_pkg::CMD_DELETE, 2, 1, 0, 0, 0, 0, 0, 0));
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i]);
      idle_gap();
    end

    // fill heap 5 to overflow
    for (int i = 0; i <= mdh_pkg::HEAP_DEPTH; i++) begin
      s = row(mdh_pkg::CMD_INSERT, 5, $urandom, $urandom, $urandom, 0, 0, 0, 0);
      send_item(s);
    end

    target = 570;
    for (int i = 0; i < target; i++) begin
      s = row(mdh_pkg::CMD_INSERT, $urandom, $urandom, $urandom, $urandom, 0, 0, 0, 0);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: s.cmd = mdh_pkg::CMD_INSERT;
        8, 9, 10, 11, 12, 13, 14: s.cmd = mdh_pkg::CMD_DELETE;
        15, 16, 17, 18: s.cmd = mdh_pkg::CMD_QUERY;
        default: s.cmd = CMD_UNUSED;
      endcase
      if ($urandom_range(0, 7) == 0)
        s.prio = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      else if ($urandom_range(0, 2) == 0)
        s.prio = $urandom_range(0, 15);
      send_item(s);
      idle_gap();
    end
    // drain heap 5
    for (int i = 0; i < mdh_pkg::HEAP_DEPTH + 1; i++) begin
      send_item(row(mdh_pkg::CMD_DELETE, 5, 5, 0, 0, 0, 0, 0, 0));
    end

    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 2000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("multiqueue_dary_heap_engine test passed");
    end else begin
      $display("multiqueue_dary_heap_engine test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
